// ----- hw/rtl/ascii_channel_frame_averager_assert.svh -----
// ----------------------------------------------------------------------------
// ascii_channel_frame_averager_assert.svh
// Assertion macros used by the frame averager top module.
// ----------------------------------------------------------------------------
`ifndef ASCII_CHANNEL_FRAME_AVERAGER_ASSERT_SVH
`define ASCII_CHANNEL_FRAME_AVERAGER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ACFA_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ACFA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/acfa_pkg.sv -----
// ----------------------------------------------------------------------------
// acfa_pkg
// Shared types, character codes and the channel gain table of the averager.
// ----------------------------------------------------------------------------
`default_nettype none

package acfa_pkg;

    localparam int CHANNELS_DEFAULT = 16;
    localparam int CH_IDX_W         = 6;   // wide enough for 64 channels
    localparam int IDX_W            = 4;   // channel_index port width
    localparam int VAL_W            = 39;  // Q16 scaled value width
    localparam int ACC_W            = 32;
    localparam int GAIN_W           = 32;
    localparam int PROD_W           = 64;

    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [ACC_W-1:0]  MAG_LIMIT  = 32'h8000_0000;
    localparam logic [ACC_W-1:0]  POS_LIMIT  = 32'h7FFF_FFFF;
    localparam logic [PROD_W-1:0] ROUND_HALF = 64'h0000_0000_0000_8000;

    typedef enum logic [1:0] {
        PH_SEEK,
        PH_HEADER,
        PH_FIELDS
    } phase_t;

    // One completed field handed from the parser to the arithmetic pipe.
    typedef struct packed {
        logic                    done;
        logic [CH_IDX_W-1:0]     ch;
        logic signed [ACC_W-1:0] value;
        logic                    first;
        logic [GAIN_W-1:0]       gain;
    } field_t;

    // Unsigned Q0.32 gains: round(2^32 * coefficient / 1000).
    // Channels 16 and up have no gain.
    function automatic logic [GAIN_W-1:0] gain_lookup(input logic [CH_IDX_W-1:0] ch);
        logic [GAIN_W-1:0] g;
        begin
            case (ch)
                6'd0:    g = 32'd214748;
                6'd1:    g = 32'd7158279;
                6'd2:    g = 32'd214748;
                6'd3:    g = 32'd214748;
                6'd4:    g = 32'd429497;
                6'd5:    g = 32'd214748;
                6'd6:    g = 32'd2147484;
                6'd7:    g = 32'd214748;
                6'd8:    g = 32'd214748;
                6'd9:    g = 32'd214748;
                6'd10:   g = 32'd429497;
                6'd11:   g = 32'd214748;
                6'd12:   g = 32'd0;
                6'd13:   g = 32'd214748;
                6'd14:   g = 32'd4294967;
                6'd15:   g = 32'd4294967;
                default: g = 32'd0;
            endcase
            return g;
        end
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/acfa_parser.sv -----
// ----------------------------------------------------------------------------
// acfa_parser
// Frame and field parser: header skip, atoi-style digit reader, channel
// counter and first-seen flags. Flags one completed field per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module acfa_parser #(
    parameter int CHANNELS = acfa_pkg::CHANNELS_DEFAULT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           accept,
    input  wire logic [7:0]     data_byte,
    input  wire logic           last_in_buffer,
    output acfa_pkg::field_t    fld
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

    acfa_pkg::phase_t        phase_reg, phase_next;
    logic [CH_W-1:0]         counter_reg, counter_next;
    logic [acfa_pkg::ACC_W-1:0] acc_reg, acc_next;
    logic                    started_reg, started_next;
    logic                    neg_reg, neg_next;
    logic                    closed_reg, closed_next;
    logic [CHANNELS-1:0]     seen_reg, seen_next;

    logic                    is_term;
    logic                    is_digit;
    logic                    is_blank;
    logic                    is_sign;
    logic                    complete;
    logic [35:0]             acc_mul;
    logic [acfa_pkg::ACC_W-1:0] acc_sat;
    logic signed [acfa_pkg::ACC_W-1:0] value;
    logic [acfa_pkg::ACC_W:0]   neg_mag;

    assign is_term  = (data_byte == acfa_pkg::CHAR_SEMI) || (data_byte == acfa_pkg::CHAR_HASH);
    assign is_digit = (data_byte >= acfa_pkg::CHAR_ZERO) && (data_byte <= acfa_pkg::CHAR_NINE);
    assign is_blank = (data_byte == acfa_pkg::CHAR_SPACE) ||
                      ((data_byte >= acfa_pkg::CHAR_TAB) && (data_byte <= acfa_pkg::CHAR_CR));
    assign is_sign  = (data_byte == acfa_pkg::CHAR_PLUS) || (data_byte == acfa_pkg::CHAR_MINUS);
    assign complete = accept && (phase_reg == acfa_pkg::PH_FIELDS) && is_term;

    // acc*10 + digit, saturated at 2^31
    assign acc_mul = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1)
                   + {32'd0, data_byte[3:0]};
    assign acc_sat = (acc_mul > {4'd0, acfa_pkg::MAG_LIMIT}) ? acfa_pkg::MAG_LIMIT
                                                             : acc_mul[31:0];

    assign neg_mag = -{1'b0, acc_reg};
    always_comb
    begin
        if (neg_reg)
            value = $signed(neg_mag[acfa_pkg::ACC_W-1:0]);
        else if (acc_reg > acfa_pkg::POS_LIMIT)
            value = $signed(acfa_pkg::POS_LIMIT);
        else
            value = $signed(acc_reg);
    end

    // next state of the frame phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            case (phase_reg)
                acfa_pkg::PH_SEEK:
                begin
                    if (data_byte == acfa_pkg::CHAR_HASH)
                        phase_next = acfa_pkg::PH_HEADER;
                end
                acfa_pkg::PH_HEADER:
                begin
                    if (data_byte == acfa_pkg::CHAR_SEMI)
                        phase_next = acfa_pkg::PH_FIELDS;
                end
                acfa_pkg::PH_FIELDS:
                begin
                    if (is_term && ((data_byte == acfa_pkg::CHAR_HASH) ||
                                    (counter_reg == CH_LAST)))
                        phase_next = acfa_pkg::PH_SEEK;
                end
                default: phase_next = acfa_pkg::PH_SEEK;
            endcase
            if (last_in_buffer)
                phase_next = acfa_pkg::PH_SEEK;
        end
    end

    // counter, digit reader and first-seen flags
    always_comb
    begin
        counter_next = counter_reg;
        acc_next     = acc_reg;
        started_next = started_reg;
        neg_next     = neg_reg;
        closed_next  = closed_reg;
        seen_next    = seen_reg;
        if (accept)
        begin
            case (phase_reg)
                acfa_pkg::PH_HEADER:
                begin
                    if (data_byte == acfa_pkg::CHAR_SEMI)
                    begin
                        counter_next = '0;
                        acc_next     = '0;
                        started_next = 1'b0;
                        neg_next     = 1'b0;
                        closed_next  = 1'b0;
                    end
                end
                acfa_pkg::PH_FIELDS:
                begin
                    if (is_term)
                    begin
                        seen_next[counter_reg] = 1'b1;
                        acc_next     = '0;
                        started_next = 1'b0;
                        neg_next     = 1'b0;
                        closed_next  = 1'b0;
                        if ((data_byte == acfa_pkg::CHAR_HASH) || (counter_reg == CH_LAST))
                            counter_next = '0;
                        else
                            counter_next = counter_reg + 1'b1;
                    end
                    else if (!closed_reg)
                    begin
                        if (!started_reg && is_blank)
                            acc_next = acc_reg;
                        else if (!started_reg && is_sign)
                        begin
                            started_next = 1'b1;
                            neg_next     = (data_byte == acfa_pkg::CHAR_MINUS);
                        end
                        else if (!is_digit)
                            closed_next = 1'b1;
                        else
                        begin
                            started_next = 1'b1;
                            acc_next     = acc_sat;
                        end
                    end
                end
                default: counter_next = counter_reg;
            endcase
            if (last_in_buffer)
            begin
                counter_next = '0;
                acc_next     = '0;
                started_next = 1'b0;
                neg_next     = 1'b0;
                closed_next  = 1'b0;
                seen_next    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= acfa_pkg::PH_SEEK;
            counter_reg <= '0;
            acc_reg     <= '0;
            started_reg <= 1'b0;
            neg_reg     <= 1'b0;
            closed_reg  <= 1'b0;
            seen_reg    <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            counter_reg <= counter_next;
            acc_reg     <= acc_next;
            started_reg <= started_next;
            neg_reg     <= neg_next;
            closed_reg  <= closed_next;
            seen_reg    <= seen_next;
        end
    end

    always_comb
    begin
        fld.done  = complete;
        fld.ch    = acfa_pkg::CH_IDX_W'(counter_reg);
        fld.value = value;
        fld.first = !seen_reg[counter_reg];
        fld.gain  = acfa_pkg::gain_lookup(acfa_pkg::CH_IDX_W'(counter_reg));
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ascii_channel_frame_averager.sv -----
// Pipeline: a result reaches out_valid through four registers (field reg,
//   multiply, round, average) after the ';' or '#' beat that ends its field.
// Throughput: one input beat per cycle. Once a held output has filled all
//   four stages, any beat stalls, whether or not it ends a field.
// Reset: rst_n (async, active low) returns the parser to frame search and
//   clears first-seen flags and all pipe valids; no clearing pass is needed.
// ----------------------------------------------------------------------------
// ascii_channel_frame_averager
// Parses '#'-framed text into decimal fields, scales each by its channel gain
// to signed Q16 and keeps a running (old+new)>>1 average per channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ascii_channel_frame_averager #(
    parameter int CHANNELS = acfa_pkg::CHANNELS_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output      logic                              in_stall,
    input  wire logic [7:0]                        data_byte,
    input  wire logic                              last_in_buffer,
    output      logic                              out_valid,
    input  wire logic                              out_stall,
    output      logic [acfa_pkg::IDX_W-1:0]        channel_index,
    output      logic signed [acfa_pkg::VAL_W-1:0] scaled_value,
    output      logic                              first_in_buffer
);

`include "ascii_channel_frame_averager_assert.svh"

    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SUM_W = acfa_pkg::VAL_W + 1;

    // Handshake: a beat is taken whenever the field stage can accept a new
    // entry. Only terminator beats load the pipe, so stalls appear only when
    // the output backs up far enough to fill every stage.
    logic in_accept;
    acfa_pkg::field_t fld;

    // stage 1: field value, channel, gain
    logic                                 s1_valid_reg;
    logic signed [acfa_pkg::ACC_W-1:0]    s1_value_reg;
    logic [acfa_pkg::GAIN_W-1:0]          s1_gain_reg;
    logic [acfa_pkg::CH_IDX_W-1:0]        s1_ch_reg;
    logic                                 s1_first_reg;

    // stage 2: raw Q32 product
    logic                                 s2_valid_reg;
    logic signed [acfa_pkg::PROD_W-1:0]   s2_prod_reg;
    logic [acfa_pkg::CH_IDX_W-1:0]        s2_ch_reg;
    logic                                 s2_first_reg;

    // stage 3: rounded Q16 value plus the channel's stored value
    logic                                 s3_valid_reg;
    logic signed [acfa_pkg::VAL_W-1:0]    s3_scaled_reg;
    logic signed [acfa_pkg::VAL_W-1:0]    s3_old_reg;
    logic [acfa_pkg::CH_IDX_W-1:0]        s3_ch_reg;
    logic                                 s3_first_reg;

    // output register
    logic                                 out_valid_reg;
    logic signed [acfa_pkg::VAL_W-1:0]    out_value_reg;
    logic [acfa_pkg::IDX_W-1:0]           out_idx_reg;
    logic                                 out_first_reg;

    logic s1_move, s2_move, s3_move;
    logic s1_free, s2_free, s3_free;

    logic signed [acfa_pkg::PROD_W:0]   prod_full;
    logic signed [acfa_pkg::PROD_W-1:0] prod_rnd;
    logic signed [SUM_W-1:0]            avg_sum;
    logic signed [acfa_pkg::VAL_W-1:0]  avg_value;
    logic [CH_W-1:0]                    s2_addr;
    logic [CH_W-1:0]                    s3_addr;

    // Per-channel running values; an entry is only used after the first
    // field of its channel in this buffer has written it.
    logic signed [acfa_pkg::VAL_W-1:0]  val_mem [CHANNELS];

    // Pipe moves: each stage advances when the one after it is free.
    assign s3_move  = s3_valid_reg && (!out_valid_reg || !out_stall);
    assign s3_free  = !s3_valid_reg || s3_move;
    assign s2_move  = s2_valid_reg && s3_free;
    assign s2_free  = !s2_valid_reg || s2_move;
    assign s1_move  = s1_valid_reg && s2_free;
    assign s1_free  = !s1_valid_reg || s1_move;

    assign in_stall  = !s1_free;
    assign in_accept = in_valid && !in_stall;

    acfa_parser #(
        .CHANNELS (CHANNELS)
    ) u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (in_accept),
        .data_byte      (data_byte),
        .last_in_buffer (last_in_buffer),
        .fld            (fld)
    );

    // Q0.32 gain is unsigned: zero-extend before the signed multiply.
    assign prod_full = s1_value_reg * $signed({1'b0, s1_gain_reg});
    // Round to nearest at Q16: add half an LSB, arithmetic shift by 16.
    assign prod_rnd  = s2_prod_reg + $signed(acfa_pkg::ROUND_HALF);

    assign s2_addr = s2_ch_reg[CH_W-1:0];
    assign s3_addr = s3_ch_reg[CH_W-1:0];

    // Floor average of stored and new value; a channel's first field passes as is.
    assign avg_sum   = {s3_old_reg[acfa_pkg::VAL_W-1], s3_old_reg}
                     + {s3_scaled_reg[acfa_pkg::VAL_W-1], s3_scaled_reg};
    assign avg_value = s3_first_reg ? s3_scaled_reg : avg_sum[SUM_W-1:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
                s1_valid_reg <= fld.done;
            if (s2_free)
                s2_valid_reg <= s1_valid_reg;
            if (s3_free)
                s3_valid_reg <= s2_valid_reg;
            if (!out_valid_reg || !out_stall)
                out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free && fld.done)
        begin
            s1_value_reg <= fld.value;
            s1_gain_reg  <= fld.gain;
            s1_ch_reg    <= fld.ch;
            s1_first_reg <= fld.first;
        end
        if (s1_move)
        begin
            s2_prod_reg  <= prod_full[acfa_pkg::PROD_W-1:0];
            s2_ch_reg    <= s1_ch_reg;
            s2_first_reg <= s1_first_reg;
        end
        if (s2_move)
        begin
            s3_scaled_reg <= prod_rnd[acfa_pkg::VAL_W+15:16];
            s3_ch_reg     <= s2_ch_reg;
            s3_first_reg  <= s2_first_reg;
        end
        if (s3_move)
        begin
            out_value_reg <= avg_value;
            out_idx_reg   <= s3_ch_reg[acfa_pkg::IDX_W-1:0];
            out_first_reg <= s3_first_reg;
        end
    end

    // Value store: written as a result leaves stage 3, read as an item
    // enters it. A same-channel write in that cycle is forwarded.
    always_ff @(posedge clk)
    begin
        if (s3_move)
            val_mem[s3_addr] <= avg_value;
        if (s2_move)
        begin
            if (s3_move && (s3_addr == s2_addr))
                s3_old_reg <= avg_value;
            else
                s3_old_reg <= val_mem[s2_addr];
        end
    end

    assign out_valid       = out_valid_reg;
    assign channel_index   = out_idx_reg;
    assign scaled_value    = out_value_reg;
    assign first_in_buffer = out_first_reg;

    // A field can only complete on an accepted beat.
    `ACFA_ASSERT_NOW(a_done_on_accept, fld.done, in_accept, "field completed without a beat")
    // Input is held back only while the field stage is occupied.
    `ACFA_ASSERT_NOW(a_stall_needs_s1, in_stall, s1_valid_reg, "stall with empty field stage")
    // A blocked stage-3 item keeps its channel until it leaves.
    `ACFA_ASSERT_NEXT(a_s3_hold, s3_valid_reg && !s3_move,
                      s3_valid_reg && $stable(s3_ch_reg), "stage 3 item lost while blocked")

endmodule

`default_nettype wire
